// ===== rtl/core/bba_pkg.sv =====
// Shared widths, operation codes and defaults for the bitmap block allocator.
`timescale 1ns / 1ps

package bba_pkg;

  localparam int IDX_W = 16;   // block_index / result_index width
  localparam int CNT_W = 17;   // free counter width
  localparam int OP_W  = 2;

  localparam int NBLOCKS_DEF   = 65536;
  localparam int WORD_BITS_DEF = 64;
  localparam int START_RESET   = 65536;
  localparam int CNT_MAX       = 131071;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd3;

endpackage

// ===== rtl/core/bba_if.sv =====
// Valid/ready channel interfaces for request, result and configuration items.
`timescale 1ns / 1ps

interface bba_in_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IDX_W-1:0] block_index;
  logic             bit_value;

  modport source (output valid, operation, block_index, bit_value, input ready);
  modport sink   (input valid, operation, block_index, bit_value, output ready);
endinterface

interface bba_out_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] result_index;
  logic             read_value;
  logic             status;
  logic [CNT_W-1:0] free_remaining;

  modport source (output valid, result_index, read_value, status, free_remaining,
                  input ready);
  modport sink   (input valid, result_index, read_value, status, free_remaining,
                  output ready);
endinterface

interface bba_cfg_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/bba_idx_div.sv =====
// Splits a block number into bitmap word address and bit position (2-stage).
`timescale 1ns / 1ps

module bba_idx_div import bba_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int AW        = 10
) (
  input  logic                           clk,
  input  logic [IDX_W-1:0]               idx,
  output logic [AW-1:0]                  word,
  output logic [$clog2(WORD_BITS)-1:0]   bpos
);

  localparam int BW    = $clog2(WORD_BITS);
  // exact reciprocal for every IDX_W-bit dividend
  localparam int SH    = IDX_W + BW;
  localparam int RECIP = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PW    = IDX_W + 18;

  logic [PW-1:0]    prod;
  logic [IDX_W-1:0] q_r;
  logic [IDX_W-1:0] rem;
  logic [AW-1:0]    word_r;
  logic [BW-1:0]    bpos_r;

  assign prod = PW'(idx) * PW'(RECIP);
  assign rem  = idx - IDX_W'(q_r * IDX_W'(WORD_BITS));

  always_ff @(posedge clk) begin
    q_r    <= IDX_W'(prod >> SH);
    word_r <= AW'(q_r);
    bpos_r <= rem[BW-1:0];
  end

  assign word = word_r;
  assign bpos = bpos_r;

endmodule

// ===== rtl/core/bitmap_block_allocator_unit.sv =====
// Top level: first-fit bitmap block allocator with a word-wide bitmap RAM.
//
//  channel  dir  payload                                            handshake
//  in_ch    in   operation, block_index, bit_value                  valid/ready
//  out_ch   out  result_index, read_value, status, free_remaining   valid/ready
//  cfg_ch   in   data (free_count_start, loads the free counter)    valid/ready
//
// Release, read and write pass from accept to result valid through index split, RAM
// read, read-modify-write and output load. Allocate scans bitmap words (1 to NWORDS),
// one RAM word read per cycle, and writes back the word holding the first free bit; a
// refused allocate with the counter at zero, or a block index past NBLOCKS, goes straight to the output load.
// After reset a clearing pass writes all NWORDS words (1024 by default) with
// in_ch.ready low; cfg_ch is always ready. One item in work at a time; a new item is
// accepted while the previous result waits in the output register.
`timescale 1ns / 1ps

module bitmap_block_allocator_unit import bba_pkg::*; #(
  parameter int NBLOCKS   = NBLOCKS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bba_in_if.sink    in_ch,
  bba_out_if.source out_ch,
  bba_cfg_if.sink   cfg_ch
);

  localparam int NWORDS    = (NBLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int LAST_BITS = NBLOCKS - (NWORDS - 1) * WORD_BITS;
  localparam int FREE_CAP  = (NBLOCKS < CNT_MAX) ? NBLOCKS : CNT_MAX;
  localparam int FREE_RST  = (FREE_CAP < START_RESET) ? FREE_CAP : START_RESET;

  localparam logic [AW-1:0]        LAST_ADDR = AW'(NWORDS - 1);
  localparam logic [WORD_BITS-1:0] FULL_MASK = {WORD_BITS{1'b1}};
  localparam logic [WORD_BITS-1:0] LAST_MASK = FULL_MASK >> (WORD_BITS - LAST_BITS);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DIVQ = 4'd2;
  localparam logic [3:0] S_DIVR = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_MOD  = 4'd5;
  localparam logic [3:0] S_SCAN = 4'd6;
  localparam logic [3:0] S_AWR  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  function automatic logic [BW-1:0] low_one(input logic [WORD_BITS-1:0] v);
    logic [BW-1:0] p;
    p = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) p = BW'(i);
    end
    return p;
  endfunction

  logic [3:0]           state_r, state_nxt;
  logic [AW-1:0]        clr_addr_r;

  logic [OP_W-1:0]      op_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 bitv_r;

  logic [CNT_W-1:0]     free_r;

  logic [AW-1:0]        scan_addr_r;
  logic [AW-1:0]        chk_addr_r;
  logic                 chk_v_r;
  logic [AW-1:0]        fnd_addr_r;
  logic [BW-1:0]        fnd_bpos_r;
  logic [WORD_BITS-1:0] fnd_word_r;

  logic [IDX_W-1:0]     res_index_r;
  logic                 res_rd_r;
  logic                 res_status_r;

  logic                 out_valid_r;
  logic [IDX_W-1:0]     out_index_r;
  logic                 out_rd_r;
  logic                 out_status_r;
  logic [CNT_W-1:0]     out_free_r;

  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic [AW-1:0]        raddr;
  logic                 mem_we;
  logic [AW-1:0]        waddr;
  logic [WORD_BITS-1:0] wdata;

  logic [AW-1:0]        div_word;
  logic [BW-1:0]        div_bpos;
  logic [WORD_BITS-1:0] bmask;
  logic [WORD_BITS-1:0] mod_word;
  logic [WORD_BITS-1:0] freebits;
  logic [AW+BW-1:0]     alloc_blk;

  logic in_fire, cfg_fire, out_load;
  logic idx_in_range;

  bba_idx_div #(
    .WORD_BITS (WORD_BITS),
    .AW        (AW)
  ) u_div (
    .clk  (clk),
    .idx  (idx_r),
    .word (div_word),
    .bpos (div_bpos)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
  assign out_load     = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);
  assign idx_in_range = (32'(in_ch.block_index) < 32'(NBLOCKS));

  // bitmap RAM
  assign raddr = (state_r == S_SCAN) ? scan_addr_r : div_word;

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign bmask = WORD_BITS'(1) << div_bpos;

  always_comb begin
    mod_word = rdata_r;
    if (op_r == OP_RELEASE || (op_r == OP_WRITE && !bitv_r)) begin
      mod_word = rdata_r & ~bmask;
    end else if (op_r == OP_WRITE) begin
      mod_word = rdata_r | bmask;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = div_word;
    wdata  = mod_word;
    unique case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        waddr  = clr_addr_r;
        wdata  = '0;
      end
      S_MOD: mem_we = (op_r != OP_READ);
      S_AWR: begin
        mem_we = 1'b1;
        waddr  = fnd_addr_r;
        wdata  = fnd_word_r | (WORD_BITS'(1) << fnd_bpos_r);
      end
      default: mem_we = 1'b0;
    endcase
  end

  // bits past NBLOCKS in the last word never count as free
  assign freebits  = ~rdata_r & ((chk_addr_r == LAST_ADDR) ? LAST_MASK : FULL_MASK);
  assign alloc_blk = (AW+BW)'(fnd_addr_r) * (AW+BW)'(WORD_BITS) + (AW+BW)'(fnd_bpos_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (clr_addr_r == LAST_ADDR) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.operation == OP_ALLOC) begin
            state_nxt = (free_r == '0) ? S_FIN : S_SCAN;
          end else begin
            state_nxt = idx_in_range ? S_DIVQ : S_FIN;
          end
        end
      end
      S_DIVQ: state_nxt = S_DIVR;
      S_DIVR: state_nxt = S_RD;
      S_RD:   state_nxt = S_MOD;
      S_MOD:  state_nxt = S_FIN;
      S_SCAN: begin
        if (chk_v_r && freebits != '0)          state_nxt = S_AWR;
        else if (chk_v_r && chk_addr_r == LAST_ADDR) state_nxt = S_FIN;
      end
      S_AWR:  state_nxt = S_FIN;
      S_FIN:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      free_r      <= CNT_W'(FREE_RST);
      out_valid_r <= 1'b0;
      chk_v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_addr_r <= clr_addr_r + AW'(1);

      if (cfg_fire) begin
        free_r <= (cfg_ch.data > CNT_W'(FREE_CAP)) ? CNT_W'(FREE_CAP) : cfg_ch.data;
      end else if (state_r == S_MOD && op_r == OP_RELEASE && free_r < CNT_W'(FREE_CAP)) begin
        free_r <= free_r + CNT_W'(1);
      end else if (state_r == S_AWR && free_r != '0) begin
        free_r <= free_r - CNT_W'(1);
      end

      if (state_r == S_SCAN) chk_v_r <= 1'b1;
      else                   chk_v_r <= 1'b0;

      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r         <= in_ch.operation;
      idx_r        <= in_ch.block_index;
      bitv_r       <= in_ch.bit_value;
      scan_addr_r  <= '0;
      res_index_r  <= (in_ch.operation == OP_ALLOC) ? '0 : in_ch.block_index;
      res_rd_r     <= 1'b0;
      res_status_r <= (in_ch.operation == OP_ALLOC);
    end

    if (state_r == S_SCAN) begin
      chk_addr_r <= scan_addr_r;
      if (scan_addr_r != LAST_ADDR) scan_addr_r <= scan_addr_r + AW'(1);
      fnd_addr_r <= chk_addr_r;
      fnd_bpos_r <= low_one(freebits);
      fnd_word_r <= rdata_r;
    end

    if (state_r == S_MOD) begin
      res_rd_r <= (op_r == OP_READ) ? rdata_r[div_bpos] : 1'b0;
    end

    if (state_r == S_AWR) begin
      res_index_r  <= IDX_W'(alloc_blk);
      res_status_r <= 1'b0;
    end

    if (out_load) begin
      out_index_r  <= res_index_r;
      out_rd_r     <= res_rd_r;
      out_status_r <= res_status_r;
      out_free_r   <= free_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_index   = out_index_r;
  assign out_ch.read_value     = out_rd_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.free_remaining = out_free_r;

`ifndef SYNTHESIS
  a_free_cap: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= CNT_W'(FREE_CAP))
    else $error("free counter above cap");

  a_alloc_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AWR && free_r != '0 && !cfg_fire) |=> free_r == $past(free_r) - CNT_W'(1))
    else $error("allocate did not decrement free counter");

  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_index_r == '0 && !out_rd_r))
    else $error("refused allocate carries index or read bit");
`endif

endmodule

// ===== tb/sv/bitmap_block_allocator_unit_test.sv =====
// Self-checking testbench for the bitmap block allocator: directed, random and boundary tests.
`timescale 1ns / 1ps

module bitmap_block_allocator_unit_test;
  import bba_pkg::*;

  localparam int FREE_CAP = (NBLOCKS_DEF < CNT_MAX) ? NBLOCKS_DEF : CNT_MAX;

  typedef struct {
    logic [IDX_W-1:0] result_index;
    logic             read_value;
    logic             status;
    logic [CNT_W-1:0] free_remaining;
  } alloc_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bba_in_if  in_ch ();
  bba_out_if out_ch ();
  bba_cfg_if cfg_ch ();

  bitmap_block_allocator_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predicted state of the allocator
  bit               block_used [NBLOCKS_DEF];
  logic [CNT_W-1:0] free_blocks;
  logic [IDX_W-1:0] last_granted;

  alloc_reply_t pending_replies [$];
  int unsigned  mismatch_count = 0;
  bit           sender_idle_on = 1'b1;
  bit           sink_stall_on  = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic alloc_reply_t predict_reply(input logic [OP_W-1:0] op,
                                                 input logic [IDX_W-1:0] idx,
                                                 input logic bv);
    alloc_reply_t r;
    int slot;
    r.result_index = idx;
    r.read_value   = 1'b0;
    r.status       = 1'b0;
    case (op)
      OP_ALLOC: begin
        slot = -1;
        // first fit; a nonzero counter does not guarantee a free bit
        if (free_blocks != 0)
          for (int b = 0; b < NBLOCKS_DEF; b++)
            if (!block_used[b]) begin
              slot = b;
              break;
            end
        if (slot < 0) begin
          r.status       = 1'b1;
          r.result_index = '0;
        end else begin
          block_used[slot] = 1'b1;
          free_blocks--;
          r.result_index = IDX_W'(slot);
          last_granted   = IDX_W'(slot);
        end
      end
      OP_RELEASE: begin
        block_used[idx] = 1'b0;
        if (free_blocks < FREE_CAP) free_blocks++;
      end
      OP_READ: r.read_value = block_used[idx];
      OP_WRITE: block_used[idx] = bv;
      default: ;
    endcase
    r.free_remaining = free_blocks;
    return r;
  endfunction

  task automatic issue_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                               input logic bv);
    int gap;
    @(negedge clk);
    if (sender_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.block_index <= idx;
    in_ch.bit_value   <= bv;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_replies.push_back(predict_reply(op, idx, bv));
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  task automatic load_free_count(input logic [CNT_W-1:0] value);
    wait_all_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    free_blocks = (value > FREE_CAP) ? CNT_W'(FREE_CAP) : value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // result sink with random stall bursts
  initial begin : result_sink
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_stall_on && hold == 0 && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 3);
      out_ch.ready <= (hold == 0);
      if (hold != 0) hold--;
    end
  end

  always @(posedge clk) begin : reply_check
    alloc_reply_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_replies.size() == 0) begin
        log_mismatch($sformatf("unexpected result index %0d", out_ch.result_index));
      end else begin
        want = pending_replies.pop_front();
        if (out_ch.result_index !== want.result_index)
          log_mismatch($sformatf("result_index exp %0d got %0d",
                                 want.result_index, out_ch.result_index));
        if (out_ch.read_value !== want.read_value)
          log_mismatch($sformatf("read_value exp %0d got %0d",
                                 want.read_value, out_ch.read_value));
        if (out_ch.status !== want.status)
          log_mismatch($sformatf("status exp %0d got %0d", want.status, out_ch.status));
        if (out_ch.free_remaining !== want.free_remaining)
          log_mismatch($sformatf("free_remaining exp %0d got %0d",
                                 want.free_remaining, out_ch.free_remaining));
      end
    end
  end

  // basic operations from a fresh bitmap with the counter at its reset value
  task automatic test_basic_ops();
    issue_request(OP_READ, 16'h0000, 1'b0);
    issue_request(OP_READ, 16'hFFFF, 1'b1);
    issue_request(OP_ALLOC, 16'hFFFF, 1'b1);
    issue_request(OP_ALLOC, 16'h0000, 1'b0);
    issue_request(OP_READ, 16'h0001, 1'b0);
    issue_request(OP_RELEASE, 16'h0001, 1'b0);
    issue_request(OP_RELEASE, 16'h0001, 1'b0);
    issue_request(OP_RELEASE, 16'h0001, 1'b0);  // counter saturates
    issue_request(OP_WRITE, 16'h0002, 1'b1);
    issue_request(OP_ALLOC, 16'h5555, 1'b0);
    issue_request(OP_ALLOC, 16'hAAAA, 1'b1);    // skips the bit set by write
    issue_request(OP_WRITE, 16'hFFFF, 1'b1);
    issue_request(OP_READ, 16'hFFFF, 1'b0);
    issue_request(OP_WRITE, 16'hFFFF, 1'b0);
    issue_request(OP_READ, 16'hFFFF, 1'b0);
    issue_request(OP_WRITE, 16'hAAAA, 1'b1);
    issue_request(OP_WRITE, 16'h5555, 1'b1);
    issue_request(OP_READ, 16'hAAAA, 1'b0);
  endtask

  // counter loads: empty, over the cap, exact cap
  task automatic test_counter_limits();
    load_free_count('0);
    issue_request(OP_ALLOC, 16'h0000, 1'b0);
    issue_request(OP_RELEASE, 16'h0000, 1'b0);
    issue_request(OP_ALLOC, 16'h0000, 1'b0);
    issue_request(OP_ALLOC, 16'h0000, 1'b0);
    load_free_count(CNT_W'(CNT_MAX));
    issue_request(OP_READ, 16'h0000, 1'b0);
    load_free_count(CNT_W'(START_RESET));
  endtask

  task automatic test_random_traffic();
    int sel;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: load_free_count(CNT_W'(START_RESET));
        1: load_free_count(CNT_W'($urandom_range(0, 6)));
        2: load_free_count(CNT_W'($urandom_range(0, CNT_MAX)));
        3: load_free_count(CNT_W'(CNT_MAX));
        default: load_free_count(CNT_W'($urandom_range(1, 200)));
      endcase
      sender_idle_on = (phase != 2);
      sink_stall_on  = (phase != 2);
      for (int n = 0; n < 70; n++) begin
        if (phase == 2 && n == 35) wait_all_results();
        sel = $urandom_range(0, 99);
        if (sel < 30)      op = OP_ALLOC;
        else if (sel < 55) op = OP_RELEASE;
        else if (sel < 80) op = OP_READ;
        else               op = OP_WRITE;
        // mostly the low region where allocations land
        sel = $urandom_range(0, 19);
        if (sel < 4)       idx = last_granted;
        else if (sel < 8)  idx = IDX_W'($urandom_range(0, 65535));
        else               idx = IDX_W'($urandom_range(0, 255));
        issue_request(op, idx, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // first word filled by writes, so allocates scan past a word boundary
  task automatic test_word_boundary();
    sender_idle_on = 1'b0;
    sink_stall_on  = 1'b0;
    load_free_count(CNT_W'(40));
    for (int i = 0; i < 70; i++) issue_request(OP_WRITE, IDX_W'(i), 1'b1);
    issue_request(OP_ALLOC, 16'h0000, 1'b0);
    issue_request(OP_READ, 16'd12345, 1'b0);
    issue_request(OP_RELEASE, 16'hFFFF, 1'b0);
    issue_request(OP_ALLOC, 16'h0000, 1'b0);
    issue_request(OP_ALLOC, 16'h0000, 1'b0);
    issue_request(OP_WRITE, 16'd300, 1'b0);
    issue_request(OP_ALLOC, 16'h0000, 1'b0);
    issue_request(OP_RELEASE, 16'h0000, 1'b0);
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_READ;
    in_ch.block_index = '0;
    in_ch.bit_value   = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    free_blocks       = (START_RESET > FREE_CAP) ? CNT_W'(FREE_CAP) : CNT_W'(START_RESET);
    last_granted      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_counter_limits();
    test_random_traffic();
    test_word_boundary();

    wait_all_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("[bitmap_block_allocator_unit] OK");
    end else begin
      $display("[bitmap_block_allocator_unit] ERROR");
    end
    $finish;
  end

  // several times the worst case: every item an allocate scanning the whole bitmap
  initial begin
    #60_000_000;
    $display("[bitmap_block_allocator_unit] ERROR");
    $finish;
  end

endmodule
